/* hdl/ovlp_pkg.sv */
// ovlp_pkg: shared constants and helpers of the oui vendor line parser
// character codes, field widths and hex digit decode; no dependencies
package ovlp_pkg;

    localparam int NAME_CHARS_DEF = 27;
    localparam int BYTE_W         = 8;
    localparam int OUI_W          = 24;
    localparam int DIGITS_PER_OUI = 6;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;

    function automatic logic is_hex(input logic [7:0] c);
        begin
            is_hex = (c >= CH_0 && c <= CH_9) || (c >= CH_LA && c <= CH_LF_HEX)
                  || (c >= CH_UA && c <= CH_UF);
        end
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] t;
        begin
            if (c >= CH_0 && c <= CH_9)
            begin
                t = c - CH_0;
            end
            else if (c >= CH_LA && c <= CH_LF_HEX)
            begin
                t = c - CH_LA + 8'd10;
            end
            else
            begin
                t = c - CH_UA + 8'd10;
            end
            hex_value = t[3:0];
        end
    endfunction

endpackage

/* hdl/ovlp_front.sv */
// ovlp_front: line splitter and field parser of the oui vendor line parser
// writes name bytes into the bank buffer, pushes finished records; uses ovlp_pkg
module ovlp_front #(
    parameter int NAME_CHARS = ovlp_pkg::NAME_CHARS_DEF,
    parameter int CW = $clog2(NAME_CHARS + 1),
    parameter int AW = (NAME_CHARS > 1) ? $clog2(NAME_CHARS) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,
    input  logic                        s_tlast,
    input  logic                        q_full,
    output logic                        push,
    output logic [ovlp_pkg::OUI_W-1:0]  push_oui,
    output logic [CW-1:0]               push_len,
    output logic                        wr_en,
    output logic [AW:0]                 wr_addr,
    output logic [7:0]                  wr_data
);

    typedef enum logic [1:0] {PH_DIGITS, PH_SEP, PH_NAME, PH_IGNORE} phase_t;

    phase_t                       phase_reg, phase_next;
    logic [2:0]                   dcount_reg, dcount_next;
    logic [ovlp_pkg::OUI_W-1:0]   oui_reg, oui_next;
    logic [CW-1:0]                stored_reg, stored_next;
    logic [CW-1:0]                kept_reg, kept_next;
    logic                         bank_reg, bank_next;
    logic                         accept;
    logic                         take;
    logic                         closing;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign wr_data  = s_tdata;

    always_comb
    begin
        phase_next  = phase_reg;
        dcount_next = dcount_reg;
        oui_next    = oui_reg;
        stored_next = stored_reg;
        kept_next   = kept_reg;
        bank_next   = bank_reg;
        take        = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = {bank_reg, stored_reg[AW-1:0]};
        push        = 1'b0;
        closing     = 1'b0;
        if (accept)
        begin
            if (s_tdata != ovlp_pkg::CH_LF)
            begin
                unique case (phase_reg)
                    PH_DIGITS:
                    begin
                        if (ovlp_pkg::is_hex(s_tdata))
                        begin
                            oui_next    = {oui_reg[ovlp_pkg::OUI_W-5:0],
                                           ovlp_pkg::hex_value(s_tdata)};
                            dcount_next = dcount_reg + 3'd1;
                            if (dcount_next == 3'(ovlp_pkg::DIGITS_PER_OUI))
                            begin
                                phase_next = PH_SEP;
                            end
                        end
                        else if (!(s_tdata == ovlp_pkg::CH_COLON
                                   || s_tdata == ovlp_pkg::CH_DASH
                                   || s_tdata == ovlp_pkg::CH_SPACE
                                   || s_tdata == ovlp_pkg::CH_TAB))
                        begin
                            phase_next = PH_IGNORE;
                        end
                    end
                    PH_SEP:
                    begin
                        if (s_tdata == ovlp_pkg::CH_CR)
                        begin
                            phase_next = PH_IGNORE;
                        end
                        else if (!(s_tdata == ovlp_pkg::CH_COMMA
                                   || s_tdata == ovlp_pkg::CH_TAB
                                   || s_tdata == ovlp_pkg::CH_SPACE
                                   || s_tdata == ovlp_pkg::CH_SEMI))
                        begin
                            phase_next = PH_NAME;
                            take       = 1'b1;
                        end
                    end
                    PH_NAME:
                    begin
                        if (s_tdata == ovlp_pkg::CH_TAB || s_tdata == ovlp_pkg::CH_COMMA
                            || s_tdata == ovlp_pkg::CH_CR)
                        begin
                            phase_next = PH_IGNORE;
                        end
                        else
                        begin
                            take = 1'b1;
                        end
                    end
                    PH_IGNORE:
                    begin
                    end
                endcase
            end
            if (take)
            begin
                // bytes past the buffer are dropped; a non-space one still marks all stored bytes as kept
                if (stored_reg < CW'(NAME_CHARS))
                begin
                    wr_en       = 1'b1;
                    stored_next = stored_reg + CW'(1);
                end
                if (s_tdata != ovlp_pkg::CH_SPACE)
                begin
                    kept_next = stored_next;
                end
            end
            closing = (s_tdata == ovlp_pkg::CH_LF) || s_tlast;
            if (closing)
            begin
                push = (dcount_next == 3'(ovlp_pkg::DIGITS_PER_OUI)) && (kept_next != '0);
                if (push)
                begin
                    bank_next = !bank_reg;
                end
            end
        end
    end

    assign push_oui = oui_next;
    assign push_len = kept_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_DIGITS;
            dcount_reg <= '0;
            oui_reg    <= '0;
            stored_reg <= '0;
            kept_reg   <= '0;
            bank_reg   <= 1'b0;
        end
        else
        begin
            bank_reg <= bank_next;
            if (closing)
            begin
                phase_reg  <= PH_DIGITS;
                dcount_reg <= '0;
                oui_reg    <= '0;
                stored_reg <= '0;
                kept_reg   <= '0;
            end
            else
            begin
                phase_reg  <= phase_next;
                dcount_reg <= dcount_next;
                oui_reg    <= oui_next;
                stored_reg <= stored_next;
                kept_reg   <= kept_next;
            end
        end
    end

endmodule

/* hdl/ovlp_queue.sv */
// ovlp_queue: two-entry record queue between parser and output sequencer
// one entry per name bank in use; uses ovlp_pkg
module ovlp_queue #(
    parameter int CW = 5
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic [ovlp_pkg::OUI_W-1:0]  push_oui,
    input  logic [CW-1:0]               push_len,
    input  logic                        pop,
    output logic                        full,
    output logic                        empty,
    output logic [ovlp_pkg::OUI_W-1:0]  head_oui,
    output logic [CW-1:0]               head_len
);

    logic [ovlp_pkg::OUI_W-1:0] oui_reg [2];
    logic [CW-1:0]              len_reg [2];
    logic                       wptr_reg;
    logic                       rptr_reg;
    logic [1:0]                 count_reg, count_next;

    assign full     = count_reg == 2'd2;
    assign empty    = count_reg == 2'd0;
    assign head_oui = oui_reg[rptr_reg];
    assign head_len = len_reg[rptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= !rptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            oui_reg[wptr_reg] <= push_oui;
            len_reg[wptr_reg] <= push_len;
        end
    end

endmodule

/* hdl/ovlp_back.sv */
// ovlp_back: name buffer and output sequencer of the oui vendor line parser
// two name banks in one memory, plays each queued record out a word per cycle while m_tready is high
module ovlp_back #(
    parameter int NAME_CHARS = ovlp_pkg::NAME_CHARS_DEF,
    parameter int CW = $clog2(NAME_CHARS + 1),
    parameter int AW = (NAME_CHARS > 1) ? $clog2(NAME_CHARS) : 1,
    parameter int OUT_W = 40
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [AW:0]                 wr_addr,
    input  logic [7:0]                  wr_data,
    input  logic                        q_empty,
    input  logic [ovlp_pkg::OUI_W-1:0]  head_oui,
    input  logic [CW-1:0]               head_len,
    output logic                        pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [OUT_W-1:0]            m_tdata,
    output logic                        m_tlast
);

    typedef enum logic {B_IDLE, B_SHOW} bstate_t;

    logic [7:0]    mem [2**(AW+1)];
    logic [7:0]    rd_data_reg;
    bstate_t       state_reg;
    logic [CW-1:0] pos_reg;
    logic [CW-1:0] pos_inc;
    logic          bank_reg;
    logic          rd_en;
    logic [AW:0]   rd_addr;
    logic          done;

    assign pos_inc  = pos_reg + CW'(1);
    assign done     = pos_inc == head_len;
    assign m_tvalid = state_reg == B_SHOW;
    assign m_tlast  = done;
    assign m_tdata  = OUT_W'({pos_reg, rd_data_reg, head_oui});
    assign pop      = m_tvalid && m_tready && done;

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = {bank_reg, {AW{1'b0}}};
        unique case (state_reg)
            B_IDLE:
            begin
                rd_en = !q_empty;
            end
            B_SHOW:
            begin
                rd_en   = m_tready && !done;
                rd_addr = {bank_reg, pos_inc[AW-1:0]};
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            pos_reg   <= '0;
            bank_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                B_IDLE:
                begin
                    if (!q_empty)
                    begin
                        state_reg <= B_SHOW;
                        pos_reg   <= '0;
                    end
                end
                B_SHOW:
                begin
                    if (m_tready)
                    begin
                        if (done)
                        begin
                            state_reg <= B_IDLE;
                            bank_reg  <= !bank_reg;
                        end
                        else
                        begin
                            pos_reg <= pos_inc;
                        end
                    end
                end
            endcase
        end
    end

endmodule

/* hdl/oui_vendor_line_parser_unit.sv */
// oui_vendor_line_parser_unit: top level of the oui vendor line parser
// instantiates ovlp_front, ovlp_queue and ovlp_back; uses ovlp_pkg
//
// takes a vendor list text one byte word per cycle on the slave side and
// emits, for each line holding a valid six-digit oui and a non-empty name,
// one master word per name byte carrying the oui, the byte and its position,
// with tlast on the final byte. the parser accepts a byte every cycle while
// one of the two name banks is free; it holds tready low only while both
// banks hold records not yet sent out. the output sequencer first reads the
// first byte of a record from the memory in its idle state, then sends one
// name byte per cycle while tready is high. the name memory needs no clearing
// after reset.
module oui_vendor_line_parser_unit #(
    parameter int NAME_CHARS = ovlp_pkg::NAME_CHARS_DEF,
    localparam int CW = $clog2(NAME_CHARS + 1),
    localparam int OUT_W = ((ovlp_pkg::OUI_W + ovlp_pkg::BYTE_W + CW + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // text_byte
    input  logic             s_tlast,   // end_of_text
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // oui_value, name_char, char_pos, zero pad
    output logic             m_tlast    // name_done
);

    localparam int AW = (NAME_CHARS > 1) ? $clog2(NAME_CHARS) : 1;

    // record handoff from parser to queue
    logic                        push;
    logic [ovlp_pkg::OUI_W-1:0]  push_oui;
    logic [CW-1:0]               push_len;
    // name bank write port
    logic                        wr_en;
    logic [AW:0]                 wr_addr;
    logic [7:0]                  wr_data;
    // queue head seen by the sequencer
    logic                        q_full;
    logic                        q_empty;
    logic                        pop;
    logic [ovlp_pkg::OUI_W-1:0]  head_oui;
    logic [CW-1:0]               head_len;

    ovlp_front #(
        .NAME_CHARS (NAME_CHARS),
        .CW         (CW),
        .AW         (AW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .push     (push),
        .push_oui (push_oui),
        .push_len (push_len),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data)
    );

    ovlp_queue #(
        .CW (CW)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_oui (push_oui),
        .push_len (push_len),
        .pop      (pop),
        .full     (q_full),
        .empty    (q_empty),
        .head_oui (head_oui),
        .head_len (head_len)
    );

    ovlp_back #(
        .NAME_CHARS (NAME_CHARS),
        .CW         (CW),
        .AW         (AW),
        .OUT_W      (OUT_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .q_empty  (q_empty),
        .head_oui (head_oui),
        .head_len (head_len),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // an output word always belongs to a queued record
    a_out_has_record: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !q_empty)
        else $error("output word without a queued record");

    // position stays inside the record length
    a_pos_in_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[ovlp_pkg::OUI_W+ovlp_pkg::BYTE_W +: CW] < head_len))
        else $error("char position beyond record length");

    // pushed records are non-empty, fit the buffer and find room in the queue
    a_push_ok: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (push_len != '0) && (push_len <= CW'(NAME_CHARS)) && !q_full)
        else $error("bad record push");

    // finishing a record frees a bank, so the parser can take bytes again
    a_pop_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> s_tready)
        else $error("bank not released after record end");

endmodule
